@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QAT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, disabled during reset.
`define QAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

@@ hw/rtl/qat_pkg.sv @@
// Shared types and constants for the quoted argument tokenizer.
package qat_pkg;

   localparam int MAX_CAPACITY_DEFAULT = 1024;

   localparam int          CAP_W     = 11;
   localparam logic [10:0] CAP_RESET = 11'd256;

   localparam int KIND_W = 3;
   localparam logic [2:0] KIND_BYTE     = 3'd0;
   localparam logic [2:0] KIND_WORD_END = 3'd1;
   localparam logic [2:0] KIND_STR_END  = 3'd2;
   localparam logic [2:0] KIND_ERROR    = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;

   localparam logic [1:0] ADDR_CAPACITY = 2'd0;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] char_out;
      logic       string_done;
   } result_type;

endpackage

@@ hw/rtl/qat_csr.sv @@
// Configuration register block: token capacity.
module qat_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [qat_pkg::CAP_W-1:0] capacity
);

   logic [qat_pkg::CAP_W-1:0] cap_ff;
   logic [qat_pkg::CAP_W-1:0] cap_in;
   logic                      wr_en;

   // Single register; every byte offset in the word maps to it.
   assign wr_en = psel && penable && pwrite && pready;

   always_comb begin
      cap_in = cap_ff;
      if (wr_en) begin
         cap_in = pwdata[qat_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= qat_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (paddr)
         qat_pkg::ADDR_CAPACITY: prdata = {{(32 - qat_pkg::CAP_W){1'b0}}, cap_ff};
         default:                prdata = {{(32 - qat_pkg::CAP_W){1'b0}}, cap_ff};
      endcase
   end

   assign pready   = 1'b1;
   assign capacity = cap_ff;

endmodule

@@ hw/rtl/qat_parse.sv @@
// Parse state machine: mode and word byte count, one byte per step.
`include "assert_macros.svh"

module qat_parse #(
   parameter int MAX_CAPACITY = qat_pkg::MAX_CAPACITY_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                char_in,
   input  logic [qat_pkg::CAP_W-1:0] capacity,
   output qat_pkg::result_type       result
);

   localparam int WC_W   = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
   localparam int MAX_W  = $clog2(MAX_CAPACITY + 1);
   localparam int CMP_W  = ((MAX_W > qat_pkg::CAP_W) ? MAX_W : qat_pkg::CAP_W) + 1;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_QUOTE,
      MODE_ESC,
      MODE_DISCARD
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [WC_W-1:0]   wc_ff, wc_in;
   logic [CMP_W-1:0]  cap_ext, eff_cap, wc_plus2;
   logic              overflow;
   logic              do_keep;

   // Clamp capacity to the range 2..MAX_CAPACITY.
   always_comb begin
      cap_ext = CMP_W'(capacity);
      if (cap_ext < CMP_W'(2)) begin
         eff_cap = CMP_W'(2);
      end else if (cap_ext > CMP_W'(MAX_CAPACITY)) begin
         eff_cap = CMP_W'(MAX_CAPACITY);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign wc_plus2 = CMP_W'(wc_ff) + CMP_W'(2);
   assign overflow = (wc_plus2 >= eff_cap);

   always_comb begin
      mode_in = mode_ff;
      wc_in   = wc_ff;
      do_keep = 1'b0;
      result  = '0;
      case (mode_ff)
         MODE_PLAIN: begin
            if (char_in == qat_pkg::CHAR_NUL) begin
               mode_in            = MODE_PLAIN;
               wc_in              = '0;
               result.valid       = 1'b1;
               result.kind        = qat_pkg::KIND_STR_END;
               result.string_done = 1'b1;
            end else if (char_in inside {qat_pkg::CHAR_SPACE, qat_pkg::CHAR_TAB}) begin
               if (wc_ff != '0) begin
                  wc_in        = '0;
                  result.valid = 1'b1;
                  result.kind  = qat_pkg::KIND_WORD_END;
               end
            end else if (char_in == qat_pkg::CHAR_QUOTE) begin
               mode_in = MODE_QUOTE;
            end else if (char_in == qat_pkg::CHAR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               do_keep = 1'b1;
            end
         end
         MODE_QUOTE: begin
            if (char_in == qat_pkg::CHAR_NUL) begin
               mode_in            = MODE_PLAIN;
               wc_in              = '0;
               result.valid       = 1'b1;
               result.kind        = qat_pkg::KIND_ERROR;
               result.string_done = 1'b1;
            end else if (char_in == qat_pkg::CHAR_QUOTE) begin
               mode_in = MODE_PLAIN;
            end else begin
               do_keep = 1'b1;
            end
         end
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            if (char_in == qat_pkg::CHAR_NUL) begin
               wc_in              = '0;
               result.valid       = 1'b1;
               result.kind        = qat_pkg::KIND_ERROR;
               result.string_done = 1'b1;
            end else begin
               do_keep = 1'b1;
            end
         end
         default: begin
            // Drop bytes until the string ends.
            if (char_in == qat_pkg::CHAR_NUL) begin
               mode_in = MODE_PLAIN;
               wc_in   = '0;
            end
         end
      endcase

      if (do_keep) begin
         result.valid = 1'b1;
         if (overflow) begin
            mode_in            = MODE_DISCARD;
            wc_in              = '0;
            result.kind        = qat_pkg::KIND_OVERFLOW;
            result.string_done = 1'b1;
         end else begin
            wc_in           = wc_ff + WC_W'(1);
            result.kind     = qat_pkg::KIND_BYTE;
            result.char_out = char_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         wc_ff   <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         wc_ff   <= wc_in;
      end
   end

   `QAT_ASSERT_IMP(a_discard_count_zero, clock, reset, mode_ff == MODE_DISCARD, wc_ff == '0)

endmodule

@@ hw/rtl/quoted_argument_tokenizer_core.sv @@
// Top level of the quoted argument tokenizer: handshake stages and register port.
//
// Feed a command-line string on the req channel one byte per item; a zero byte
// ends the string. The rsp channel returns zero or one item per input byte:
// a kept word byte, a word end, a string end, an open-quote/escape error or an
// overflow (string_done marks the last three). Bytes that give no result
// (whitespace between words, quotes, backslash escapes, discarded bytes)
// vanish without a response.
// A byte waits in the input register; its parse result is registered in the
// result register. Throughput: one byte per cycle while rsp_stall is low, set
// by the parse step between the input register and the result register.
// Reset clears both stages, sets plain mode with an empty word and loads
// token_capacity with 256. When rsp_stall holds a result, the parse step waits
// and req_stall rises as soon as the input register holds a byte; an empty
// input register still takes one more byte.
// Write token_capacity over the APB port only while no item is in flight.
`include "assert_macros.svh"

module quoted_argument_tokenizer_core #(
   parameter int MAX_CAPACITY = qat_pkg::MAX_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_string_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_char_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [2:0]                out_kind_ff;
   logic [7:0]                out_char_ff;
   logic                      out_done_ff;
   logic                      slot_free;
   logic                      step;
   logic                      req_take;
   logic                      rsp_take;
   logic                      rsp_final;
   logic                      rsp_is_byte;
   logic [qat_pkg::CAP_W-1:0] capacity;
   qat_pkg::result_type       result;

   qat_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   qat_parse #(
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_in  (in_char_ff),
      .capacity (capacity),
      .result   (result)
   );

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = result.valid;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on acceptance / on a parse step.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
      end
      if (step) begin
         out_kind_ff <= result.kind;
         out_char_ff <= result.char_out;
         out_done_ff <= result.string_done;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_kind_ff;
   assign rsp_char_out    = out_char_ff;
   assign rsp_string_done = out_done_ff;

   assign rsp_final   = (rsp_kind == qat_pkg::KIND_STR_END) ||
                        (rsp_kind == qat_pkg::KIND_ERROR) ||
                        (rsp_kind == qat_pkg::KIND_OVERFLOW);
   assign rsp_is_byte = (rsp_kind == qat_pkg::KIND_BYTE);

   `QAT_ASSERT_IMP(a_done_matches_kind, clock, reset, rsp_valid, rsp_string_done == rsp_final)
   `QAT_ASSERT_IMP(a_char_zero_off_byte, clock, reset, rsp_valid && !rsp_is_byte, rsp_char_out == '0)
   `QAT_ASSERT_NEXT(a_held_input_stays, clock, reset, in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff)

endmodule

@@ bench/qat_token_check.sv @@
// Checker for the tokenizer: tracks register writes, predicts results and compares them.
`timescale 1ns / 1ps

module qat_token_check #(
   parameter int MAX_CAPACITY = qat_pkg::MAX_CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_char_out,
   input  logic        rsp_string_done,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output int          fail_count,
   output int          outstanding,
   output int          checked_count,
   output int          overflow_count,
   output int          open_error_count
);

   typedef enum logic [1:0] {
      SCAN_PLAIN,
      SCAN_QUOTE,
      SCAN_ESCAPE,
      SCAN_DISCARD
   } scan_mode_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_out;
      logic       string_done;
   } token_event_type;

   token_event_type           token_q[$];
   token_event_type           want;
   token_event_type           got;
   logic [qat_pkg::CAP_W-1:0] capacity;
   scan_mode_type             scan_mode;
   int                        word_len;
   int                        errors;
   int                        checked;
   int                        overflows;
   int                        open_errors;

   function automatic int clamped_capacity();
      int c;
      c = int'(capacity);
      if (c < 2) c = 2;
      if (c > MAX_CAPACITY) c = MAX_CAPACITY;
      return c;
   endfunction

   function automatic void push_event(logic [2:0] k, logic [7:0] c, logic d);
      token_event_type ev;
      ev.kind = k;
      ev.char_out = c;
      ev.string_done = d;
      token_q.push_back(ev);
   endfunction

   // A byte that would bring the word to capacity minus one turns into an overflow.
   function automatic void store_byte(logic [7:0] c);
      int n;
      n = word_len + 1;
      if (n >= clamped_capacity() - 1) begin
         scan_mode = SCAN_DISCARD;
         word_len = 0;
         push_event(qat_pkg::KIND_OVERFLOW, 8'h00, 1'b1);
      end else begin
         word_len = n;
         push_event(qat_pkg::KIND_BYTE, c, 1'b0);
      end
   endfunction

   function automatic void close_string(logic [2:0] k);
      scan_mode = SCAN_PLAIN;
      word_len = 0;
      push_event(k, 8'h00, 1'b1);
   endfunction

   function automatic void tokenize(logic [7:0] c);
      case (scan_mode)
         SCAN_PLAIN: begin
            if (c == qat_pkg::CHAR_NUL) begin
               close_string(qat_pkg::KIND_STR_END);
            end else if (c == qat_pkg::CHAR_SPACE || c == qat_pkg::CHAR_TAB) begin
               if (word_len != 0) begin
                  word_len = 0;
                  push_event(qat_pkg::KIND_WORD_END, 8'h00, 1'b0);
               end
            end else if (c == qat_pkg::CHAR_QUOTE) begin
               scan_mode = SCAN_QUOTE;
            end else if (c == qat_pkg::CHAR_BSLASH) begin
               scan_mode = SCAN_ESCAPE;
            end else begin
               store_byte(c);
            end
         end
         SCAN_QUOTE: begin
            if (c == qat_pkg::CHAR_NUL) close_string(qat_pkg::KIND_ERROR);
            else if (c == qat_pkg::CHAR_QUOTE) scan_mode = SCAN_PLAIN;
            else store_byte(c);
         end
         SCAN_ESCAPE: begin
            if (c == qat_pkg::CHAR_NUL) begin
               close_string(qat_pkg::KIND_ERROR);
            end else begin
               scan_mode = SCAN_PLAIN;
               store_byte(c);
            end
         end
         default: begin
            // drop everything until the string ends
            if (c == qat_pkg::CHAR_NUL) begin
               scan_mode = SCAN_PLAIN;
               word_len = 0;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         token_q.delete();
         capacity = qat_pkg::CAP_RESET;
         scan_mode = SCAN_PLAIN;
         word_len = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == qat_pkg::ADDR_CAPACITY)
            capacity = pwdata[qat_pkg::CAP_W-1:0];
         if (req_valid && !req_stall)
            tokenize(req_char_in);
         if (rsp_valid && !rsp_stall) begin
            got.kind = rsp_kind;
            got.char_out = rsp_char_out;
            got.string_done = rsp_string_done;
            if (token_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind %0d char %h done %b",
                        $time, got.kind, got.char_out, got.string_done);
            end else begin
               want = token_q.pop_front();
               checked++;
               if (want.kind == qat_pkg::KIND_OVERFLOW) overflows++;
               if (want.kind == qat_pkg::KIND_ERROR) open_errors++;
               if (got !== want) begin
                  errors++;
                  if (got.kind !== want.kind)
                     $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
                  if (got.char_out !== want.char_out)
                     $display("%0t: char_out expected %h got %h",
                              $time, want.char_out, got.char_out);
                  if (got.string_done !== want.string_done)
                     $display("%0t: string_done expected %b got %b",
                              $time, want.string_done, got.string_done);
               end
            end
         end
      end
      fail_count <= errors;
      outstanding <= token_q.size();
      checked_count <= checked;
      overflow_count <= overflows;
      open_error_count <= open_errors;
   end

endmodule

@@ bench/tb_quoted_argument_tokenizer_core.sv @@
// Testbench top for the tokenizer: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_quoted_argument_tokenizer_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_char_out;
   logic        rsp_string_done;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = qat_pkg::ADDR_CAPACITY;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count;
   int outstanding;
   int checked_count;
   int overflow_count;
   int open_error_count;

   int idle_mode = 0;
   int stall_left = 0;
   int items_sent = 0;
   int max_run = 5;

   always #2 clock = ~clock;

   quoted_argument_tokenizer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_char_in(req_char_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out), .rsp_string_done(rsp_string_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   qat_token_check token_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_char_in(req_char_in),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out), .rsp_string_done(rsp_string_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .outstanding(outstanding),
      .checked_count(checked_count), .overflow_count(overflow_count),
      .open_error_count(open_error_count)
   );

   // Result-side backpressure in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_mode != 0 && !reset &&
                   $urandom_range(0, idle_mode == 1 ? 12 : 3) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 9 : 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Hold the sender until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [qat_pkg::CAP_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= qat_pkg::ADDR_CAPACITY;
      pwdata <= ($urandom() & ~32'h7FF) | {21'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      while (c == qat_pkg::CHAR_SPACE || c == qat_pkg::CHAR_TAB ||
             c == qat_pkg::CHAR_QUOTE || c == qat_pkg::CHAR_BSLASH)
         c = 8'($urandom_range(1, 255));
      return c;
   endfunction

   function automatic logic [7:0] quoted_char();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: c = qat_pkg::CHAR_SPACE;
         1: c = qat_pkg::CHAR_TAB;
         2: c = qat_pkg::CHAR_BSLASH;
         default: begin
            c = 8'($urandom_range(1, 255));
            while (c == qat_pkg::CHAR_QUOTE) c = 8'($urandom_range(1, 255));
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] blank_char();
      return $urandom_range(0, 1) ? qat_pkg::CHAR_SPACE : qat_pkg::CHAR_TAB;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      case ($urandom_range(0, 6))
         0: c = qat_pkg::CHAR_SPACE;
         1: c = qat_pkg::CHAR_TAB;
         2: c = qat_pkg::CHAR_QUOTE;
         3: c = qat_pkg::CHAR_BSLASH;
         default: c = 8'($urandom_range(1, 255));
      endcase
      return c;
   endfunction

   // Mostly well-formed command lines; a few end inside a quote or after a backslash.
   task automatic send_command_line();
      int shape;
      int words;
      int len;
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) send_byte(noise_char());
      end else begin
         repeat ($urandom_range(0, 2)) send_byte(blank_char());
         words = $urandom_range(1, 4);
         for (int w = 0; w < words; w++) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     len = $urandom_range(1, max_run);
                     repeat (len) send_byte(plain_char());
                  end
                  2: begin
                     send_byte(qat_pkg::CHAR_QUOTE);
                     len = $urandom_range(0, max_run);
                     repeat (len) send_byte(quoted_char());
                     send_byte(qat_pkg::CHAR_QUOTE);
                  end
                  default: begin
                     send_byte(qat_pkg::CHAR_BSLASH);
                     send_byte(8'($urandom_range(1, 255)));
                  end
               endcase
            end
            if (w < words - 1)
               repeat ($urandom_range(1, 2)) send_byte(blank_char());
         end
         case (shape)
            1: repeat ($urandom_range(1, 3)) send_byte(blank_char());
            2: begin
               send_byte(qat_pkg::CHAR_QUOTE);
               repeat ($urandom_range(0, 3)) send_byte(quoted_char());
            end
            3: send_byte(qat_pkg::CHAR_BSLASH);
            default: ;
         endcase
      end
      send_byte(qat_pkg::CHAR_NUL);
   endtask

   initial begin
      logic [qat_pkg::CAP_W-1:0] caps [12];
      int phase_end;

      caps = '{11'd0, 11'd2047, 11'd3, 11'd1, 11'd7, 11'd1024,
               11'd2, 11'd12, 11'd1025, 11'd5, 11'd30, 11'd9};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed strings at the reset capacity.
      send_byte(qat_pkg::CHAR_NUL);
      send_byte(8'h01);
      send_byte(8'hFF);
      send_byte(qat_pkg::CHAR_SPACE);
      send_byte(qat_pkg::CHAR_TAB);
      send_byte(qat_pkg::CHAR_QUOTE);
      send_byte(qat_pkg::CHAR_QUOTE);
      send_byte(qat_pkg::CHAR_SPACE);
      send_byte(qat_pkg::CHAR_QUOTE);
      send_byte(qat_pkg::CHAR_SPACE);
      send_byte(qat_pkg::CHAR_BSLASH);
      send_byte(qat_pkg::CHAR_QUOTE);
      send_byte(qat_pkg::CHAR_BSLASH);
      send_byte(qat_pkg::CHAR_SPACE);
      send_byte(8'h7F);
      send_byte(8'h80);
      send_byte(qat_pkg::CHAR_NUL);
      send_byte(qat_pkg::CHAR_QUOTE);
      send_byte(8'h41);
      send_byte(qat_pkg::CHAR_NUL);
      send_byte(qat_pkg::CHAR_BSLASH);
      send_byte(qat_pkg::CHAR_NUL);

      for (int p = 0; p < 12; p++) begin
         drain();
         write_capacity(caps[p]);
         idle_mode = (p == 11) ? 0 : p % 3;
         max_run = (caps[p] >= 11'd1024) ? 8 : 5;
         if (p == 0) begin
            // overflow on the first byte, then discard through the terminator
            send_byte(8'h61);
            send_byte(8'h62);
            send_byte(qat_pkg::CHAR_NUL);
         end
         phase_end = items_sent + 70;
         while (items_sent < phase_end) begin
            send_command_line();
            if (p == 4 && items_sent >= phase_end - 40 && items_sent < phase_end - 30)
               drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes over 13 capacity settings; checked %0d results",
               items_sent, checked_count);
      $display("including %0d overflows and %0d open quote/escape errors",
               overflow_count, open_error_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
